### rtl/interval_range_table_unit_macros.svh
// Assertion macros for the interval range table.
// Used by the top level; expects a clock named i_clk and a reset named i_rst_n in scope.
`ifndef INTERVAL_RANGE_TABLE_UNIT_MACROS_SVH
`define INTERVAL_RANGE_TABLE_UNIT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define IRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks a property at every clock edge, reset included.
`define IRT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### rtl/irt_pkg.sv
// Shared types and constants for the interval range table.
// No dependencies; imported by every module of the block.
package irt_pkg;

    localparam int MAX_RANGES = 16;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int NUM_W      = $clog2(2 * MAX_RANGES + 2);

    localparam logic [2:0] CMD_ALLOC   = 3'd0;
    localparam logic [2:0] CMD_RELEASE = 3'd1;
    localparam logic [2:0] CMD_CHECK   = 3'd2;
    localparam logic [2:0] CMD_LIST    = 3'd3;
    localparam logic [2:0] CMD_MERGE   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_range;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] range_start;
        logic signed [31:0] range_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic               available;
        logic signed [31:0] out_start;
        logic signed [31:0] out_end;
        logic               entry_valid;
        logic               last;
    } t_out_item;

endpackage

### rtl/interval_range_table_unit.sv
// Interval range table: keeps sorted disjoint half-open ranges and serves requests.
// Usage notes:
//   The input channel (i_in_valid, o_in_stall, i_in_data) carries one request per
//   transaction: allocate, release, check, list stored or list merged.
//   The output channel (o_out_valid, i_out_stall, o_out_data) carries results; the
//   final result of each request has last set; lists give one per (merged) range.
//   A request is taken only when the block is idle. Valid requests walk the
//   whole row of MAX_RANGES storage cells, one cell per cycle unless a result
//   waits on a stalled receiver, then pass through a finishing state before
//   the block is idle again. Invalid allocate, release or check ranges and
//   unknown commands skip the walk and go straight to the finishing state.
//   Changes build the new table in a second cell row and copy it over in the
//   finishing state, so a refused change leaves the table untouched.
//   A result sits in an output register; while the receiver stalls, the walk
//   pauses at the next cycle that must produce a result.
//   Synchronous active-low reset empties the table and drops any pending
//   result; the cell contents themselves are not cleared.
// Depends on irt_pkg, irt_cell, irt_cut and the assertion macro header.
`include "interval_range_table_unit_macros.svh"

module interval_range_table_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  irt_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output irt_pkg::t_out_item o_out_data
);
    import irt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH} t_state;

    t_state     r_state;
    logic [2:0] r_cmd;
    t_range     r_req;
    logic       r_invalid;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic       r_ins;
    logic       r_free;
    t_range     r_run;
    logic       r_out_valid;
    t_out_item  r_out;

    t_range     a_data [MAX_RANGES];
    t_range     b_data [MAX_RANGES];
    t_range     a_load_data [MAX_RANGES];
    t_range     b_load_data [MAX_RANGES];
    logic       b_load [MAX_RANGES];

    t_range     head;
    logic       hv;
    t_range     wr [3];
    logic [1:0] wr_cnt;
    logic       cut_insert, cut_overlap;

    logic       in_fire, can_emit, is_chg, is_alloc;
    logic       need_emit, step, walk_step, fin_emit, fin_fire, emit_fire;
    logic       ins_final, commit, over;
    logic [NUM_W-1:0] n_final;
    t_out_item  n_out;

    // Handshake and request decode.
    assign in_fire  = i_in_valid && (r_state == S_IDLE);
    assign can_emit = !r_out_valid || !i_out_stall;
    assign is_alloc = (r_cmd == CMD_ALLOC);
    assign is_chg   = (r_cmd == CMD_ALLOC) || (r_cmd == CMD_RELEASE);
    assign head     = a_data[0];
    assign hv       = (r_idx < r_cnt);

    irt_cut u_cut (
        .i_entry      (head),
        .i_entry_valid(hv),
        .i_req        (r_req),
        .i_is_alloc   (is_alloc),
        .i_inserted   (r_ins),
        .o_wr         (wr),
        .o_wr_cnt     (wr_cnt),
        .o_insert     (cut_insert),
        .o_overlap    (cut_overlap)
    );

    // A walk step that must produce a result waits for the output register.
    always_comb begin
        need_emit = 1'b0;
        if (r_cmd == CMD_LIST) begin
            need_emit = hv;
        end else if (r_cmd == CMD_MERGE) begin
            need_emit = hv && (r_idx != '0) && !(r_run.hi >= head.lo);
        end
    end
    assign step      = !need_emit || can_emit;
    assign walk_step = (r_state == S_WALK) && step;

    // Finishing state: final insertion, capacity test and commit.
    assign ins_final = is_alloc && !r_ins;
    assign n_final   = r_num + NUM_W'(ins_final);
    assign over      = (n_final > NUM_W'(MAX_RANGES));
    assign fin_emit  = r_invalid || !((r_cmd == CMD_LIST) && (r_cnt != '0));
    assign fin_fire  = (r_state == S_FINISH) && can_emit;
    assign commit    = fin_fire && !r_invalid && is_chg && !over;
    assign emit_fire = (walk_step && need_emit) || (fin_fire && fin_emit);

    // Result value for the current cycle.
    always_comb begin
        n_out = '0;
        n_out.status = ST_OK;
        if (r_state == S_WALK) begin
            n_out.entry_valid = 1'b1;
            if (r_cmd == CMD_LIST) begin
                n_out.out_start = head.lo;
                n_out.out_end   = head.hi;
                n_out.last      = (CNT_W'(r_idx + 1'b1) == r_cnt);
            end else begin
                n_out.out_start = r_run.lo;
                n_out.out_end   = r_run.hi;
            end
        end else begin
            n_out.last = 1'b1;
            if (r_invalid) begin
                n_out.status = ST_INVALID;
            end else if (is_chg) begin
                n_out.status = over ? ST_FULL : ST_OK;
            end else if (r_cmd == CMD_CHECK) begin
                n_out.available = r_free;
            end else if ((r_cmd == CMD_MERGE) && (r_cnt != '0)) begin
                n_out.entry_valid = 1'b1;
                n_out.out_start   = r_run.lo;
                n_out.out_end     = r_run.hi;
            end
        end
    end

    // Table row: rotates once around per walk, loaded from the build row on commit.
    for (genvar i = 0; i < MAX_RANGES; i++) begin : g_table
        always_comb begin
            a_load_data[i] = b_data[i];
            if (ins_final && ({1'b0, r_num} == (NUM_W + 1)'(i))) begin
                a_load_data[i] = r_req;
            end
        end
        irt_cell u_a (
            .i_clk       (i_clk),
            .i_shift     (walk_step),
            .i_shift_data(a_data[(i + 1) % MAX_RANGES]),
            .i_load      (commit),
            .i_load_data (a_load_data[i]),
            .o_data      (a_data[i])
        );
    end

    // Build row: each cell takes the piece whose slot number matches its own.
    for (genvar i = 0; i < MAX_RANGES; i++) begin : g_build
        always_comb begin
            b_load[i]      = 1'b0;
            b_load_data[i] = wr[0];
            for (int j = 0; j < 3; j++) begin
                if (walk_step && is_chg && (2'(j) < wr_cnt)
                    && (({1'b0, r_num} + (NUM_W + 1)'(j)) == (NUM_W + 1)'(i))) begin
                    b_load[i]      = 1'b1;
                    b_load_data[i] = wr[j];
                end
            end
        end
        irt_cell u_b (
            .i_clk       (i_clk),
            .i_shift     (1'b0),
            .i_shift_data(b_data[i]),
            .i_load      (b_load[i]),
            .i_load_data (b_load_data[i]),
            .o_data      (b_data[i])
        );
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_num       <= '0;
            r_ins       <= 1'b0;
            r_free      <= 1'b1;
            r_invalid   <= 1'b0;
        end else begin
            if (emit_fire) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_cmd     <= i_in_data.cmd;
                        r_req     <= t_range'{lo: i_in_data.range_start,
                                              hi: i_in_data.range_end};
                        r_invalid <= (i_in_data.cmd <= CMD_CHECK)
                                     && (i_in_data.range_start >= i_in_data.range_end);
                        r_idx     <= '0;
                        r_num     <= '0;
                        r_ins     <= 1'b0;
                        r_free    <= 1'b1;
                        if (((i_in_data.cmd <= CMD_CHECK)
                             && (i_in_data.range_start >= i_in_data.range_end))
                            || (i_in_data.cmd > CMD_MERGE)) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (step) begin
                        if (is_chg) begin
                            r_num <= r_num + NUM_W'(wr_cnt);
                            r_ins <= r_ins || cut_insert;
                        end
                        if (cut_overlap) begin
                            r_free <= 1'b0;
                        end
                        if (hv) begin
                            if (r_idx == '0) begin
                                r_run <= head;
                            end else if (r_run.hi >= head.lo) begin
                                if (head.hi > r_run.hi) begin
                                    r_run.hi <= head.hi;
                                end
                            end else begin
                                r_run <= head;
                            end
                        end
                        r_idx <= CNT_W'(r_idx + 1'b1);
                        if (r_idx == CNT_W'(MAX_RANGES - 1)) begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (can_emit) begin
                        if (commit) begin
                            r_cnt <= CNT_W'(n_final);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks on the sequencer, the table size and the output after reset.
    `IRT_ASSERT(a_busy_after_accept, (i_in_valid && !o_in_stall) |=> o_in_stall, "accepted a transaction but still idle")
    `IRT_ASSERT(a_count_bound, r_cnt <= CNT_W'(MAX_RANGES), "range count exceeds capacity")
    `IRT_ASSERT(a_commit_fits, commit |-> (n_final <= NUM_W'(MAX_RANGES)), "committed a table beyond capacity")
    `IRT_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "result pending after reset")

endmodule

### rtl/irt_cell.sv
// One storage cell of the range chain: holds one range pair.
// Depends on irt_pkg for the range type.
module irt_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  irt_pkg::t_range i_shift_data,
    input  logic          i_load,
    input  irt_pkg::t_range i_load_data,
    output irt_pkg::t_range o_data
);
    import irt_pkg::*;

    t_range r_data;

    // A load has priority over taking the neighbor's value.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_data;
        end else if (i_shift) begin
            r_data <= i_shift_data;
        end
    end

    assign o_data = r_data;

endmodule

### rtl/irt_cut.sv
// Cuts the request out of one stored range and orders the resulting pieces,
// placing the new range before the first piece that starts at or after it.
// Depends on irt_pkg.
module irt_cut (
    input  irt_pkg::t_range i_entry,
    input  logic            i_entry_valid,
    input  irt_pkg::t_range i_req,
    input  logic            i_is_alloc,
    input  logic            i_inserted,
    output irt_pkg::t_range o_wr [3],
    output logic [1:0]      o_wr_cnt,
    output logic            o_insert,
    output logic            o_overlap
);
    import irt_pkg::*;

    logic   ov;
    logic   q0v, q1v, ins_ok, nb0, nb1;
    t_range q0, q1;
    logic   sv [4];
    t_range sd [4];
    t_range wr [4];
    logic [1:0] cnt;

    // Pieces left after removing the request from the entry.
    always_comb begin
        ov  = i_entry_valid && !(i_entry.hi <= i_req.lo || i_entry.lo >= i_req.hi);
        q0v = i_entry_valid && (!ov || i_entry.lo < i_req.lo);
        q0  = ov ? t_range'{lo: i_entry.lo, hi: i_req.lo} : i_entry;
        q1v = ov && (i_entry.hi > i_req.hi);
        q1  = t_range'{lo: i_req.hi, hi: i_entry.hi};
        ins_ok = i_is_alloc && !i_inserted;
        nb0 = ins_ok && q0v && (q0.lo >= i_req.lo);
        nb1 = ins_ok && !nb0 && q1v && (q1.lo >= i_req.lo);
    end

    // Pack the valid slots in order into up to three writes.
    always_comb begin
        sv[0] = nb0;  sd[0] = i_req;
        sv[1] = q0v;  sd[1] = q0;
        sv[2] = nb1;  sd[2] = i_req;
        sv[3] = q1v;  sd[3] = q1;
        cnt = 2'd0;
        for (int j = 0; j < 4; j++) begin
            wr[j] = '0;
        end
        for (int j = 0; j < 4; j++) begin
            if (sv[j]) begin
                wr[cnt] = sd[j];
                cnt     = cnt + 2'd1;
            end
        end
    end

    assign o_wr[0]   = wr[0];
    assign o_wr[1]   = wr[1];
    assign o_wr[2]   = wr[2];
    assign o_wr_cnt  = cnt;
    assign o_insert  = nb0 || nb1;
    assign o_overlap = ov;

endmodule

### sim/interval_range_table_checker.sv
// Checker for the interval range table: watches both channels, predicts results, compares.
// Depends on irt_pkg for the transaction types, command and status codes.
module interval_range_table_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  irt_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  irt_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_result_count
);
    import irt_pkg::*;

    // Shadow copy of the stored ranges.
    logic signed [31:0] shadow_lo [MAX_RANGES];
    logic signed [31:0] shadow_hi [MAX_RANGES];
    int                 shadow_count;
    t_out_item          expected_results [$];

    function automatic t_out_item make_result(logic [1:0] st, logic av, logic signed [31:0] s,
                                              logic signed [31:0] e, logic vld, logic lst);
        t_out_item r;
        r.status = st;
        r.available = av;
        r.out_start = s;
        r.out_end = e;
        r.entry_valid = vld;
        r.last = lst;
        return r;
    endfunction

    // Appends one expected result to the end of the queue.
    function automatic void queue_result(input t_out_item r);
        expected_results = {expected_results, r};
    endfunction

    // Applies one request to the shadow table and queues the results it causes.
    task automatic predict_request(input t_in_item req);
        logic signed [31:0] new_lo [MAX_RANGES + 2];
        logic signed [31:0] new_hi [MAX_RANGES + 2];
        logic signed [31:0] run_lo, run_hi, a, b;
        int                 n, pos;
        logic               is_free;
        n = 0;
        if (req.cmd <= CMD_CHECK && req.range_start >= req.range_end) begin
            queue_result(make_result(ST_INVALID, 0, 0, 0, 0, 1));
            return;
        end
        case (req.cmd)
            CMD_ALLOC, CMD_RELEASE: begin
                for (int i = 0; i < shadow_count; i++) begin
                    a = shadow_lo[i];
                    b = shadow_hi[i];
                    if (b <= req.range_start || a >= req.range_end) begin
                        new_lo[n] = a; new_hi[n] = b; n++;
                    end else begin
                        if (a < req.range_start) begin
                            new_lo[n] = a; new_hi[n] = req.range_start; n++;
                        end
                        if (b > req.range_end) begin
                            new_lo[n] = req.range_end; new_hi[n] = b; n++;
                        end
                    end
                end
                if (req.cmd == CMD_ALLOC) begin
                    pos = 0;
                    while (pos < n && new_lo[pos] < req.range_start) pos++;
                    for (int i = n; i > pos; i--) begin
                        new_lo[i] = new_lo[i - 1]; new_hi[i] = new_hi[i - 1];
                    end
                    new_lo[pos] = req.range_start;
                    new_hi[pos] = req.range_end;
                    n++;
                end
                if (n > MAX_RANGES) begin
                    queue_result(make_result(ST_FULL, 0, 0, 0, 0, 1));
                end else begin
                    for (int i = 0; i < n; i++) begin
                        shadow_lo[i] = new_lo[i]; shadow_hi[i] = new_hi[i];
                    end
                    shadow_count = n;
                    queue_result(make_result(ST_OK, 0, 0, 0, 0, 1));
                end
            end
            CMD_CHECK: begin
                is_free = 1;
                for (int i = 0; i < shadow_count; i++)
                    if (!(req.range_end <= shadow_lo[i] || req.range_start >= shadow_hi[i]))
                        is_free = 0;
                queue_result(make_result(ST_OK, is_free, 0, 0, 0, 1));
            end
            CMD_LIST: begin
                if (shadow_count == 0)
                    queue_result(make_result(ST_OK, 0, 0, 0, 0, 1));
                for (int i = 0; i < shadow_count; i++)
                    queue_result(make_result(ST_OK, 0, shadow_lo[i],
                        shadow_hi[i], 1, i + 1 == shadow_count));
            end
            CMD_MERGE: begin
                if (shadow_count == 0) begin
                    queue_result(make_result(ST_OK, 0, 0, 0, 0, 1));
                end else begin
                    run_lo = shadow_lo[0];
                    run_hi = shadow_hi[0];
                    for (int i = 1; i < shadow_count; i++) begin
                        if (run_hi >= shadow_lo[i]) begin
                            if (shadow_hi[i] > run_hi) run_hi = shadow_hi[i];
                        end else begin
                            queue_result(make_result(ST_OK, 0, run_lo,
                                run_hi, 1, 0));
                            run_lo = shadow_lo[i];
                            run_hi = shadow_hi[i];
                        end
                    end
                    queue_result(make_result(ST_OK, 0, run_lo, run_hi, 1, 1));
                end
            end
            default: begin
                queue_result(make_result(ST_OK, 0, 0, 0, 0, 1));
            end
        endcase
    endtask

    // Predict on every input transaction, compare on every output transaction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            shadow_count = 0;
            o_fail_count = 0;
            o_result_count = 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                predict_request(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                o_result_count++;
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("mismatch: unexpected result %p", i_out_data);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected %p, got %p", want, i_out_data);
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_result_count = 0;
        shadow_count = 0;
    end
endmodule

### sim/interval_range_table_unit_tb.sv
// Testbench top for the interval range table: drives requests, stalls results, gives the verdict.
// Depends on irt_pkg, interval_range_table_unit and interval_range_table_checker.
module interval_range_table_unit_tb;
    import irt_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    int        result_count;
    int        request_count;
    logic      idle_free;

    interval_range_table_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    interval_range_table_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_result_count(result_count)
    );

    // Clock generation.
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    // Sends one request, with a random gap before it, and waits for its acceptance.
    // Valid stays high after acceptance until the next request or the end of stimulus.
    task automatic send_request(input logic [2:0] cmd, input logic signed [31:0] s,
                                input logic signed [31:0] e);
        int gap;
        gap = idle_free ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1;
        in_data <= '{cmd: cmd, range_start: s, range_end: e};
        do @(posedge i_clk); while (in_stall);
        request_count++;
    endtask

    // Small-window point so that ranges touch and overlap often.
    function automatic logic signed [31:0] near_point(int base);
        return base + $signed($urandom_range(0, 60));
    endfunction

    // Receiver stall: a random stall comes before each result is taken, except in stall-free stretches.
    initial begin
        int waits;
        out_stall = 1;
        @(posedge i_rst_n);
        forever begin
            waits = idle_free ? 0 : $urandom_range(0, 7);
            if (waits != 0) begin
                out_stall <= 1;
                repeat (waits) @(posedge i_clk);
            end
            out_stall <= 0;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    initial begin
        logic [2:0]         cmd;
        logic signed [31:0] s, e;
        int                 base, roll;
        in_valid = 0;
        in_data = '0;
        i_rst_n = 0;
        idle_free = 0;
        request_count = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed part: empty lists, extremes, invalid ranges, splits, unknown codes.
        send_request(CMD_LIST, 0, 0);
        send_request(CMD_MERGE, 32'h7fffffff, 32'h80000000);
        send_request(CMD_CHECK, 32'h80000000, 32'h7fffffff);
        send_request(CMD_ALLOC, 32'h80000000, 32'h80000010);
        send_request(CMD_ALLOC, 32'h7ffffff0, 32'h7fffffff);
        send_request(CMD_ALLOC, 10, 20);
        send_request(CMD_ALLOC, 20, 30);
        send_request(CMD_ALLOC, 15, 25);
        send_request(CMD_ALLOC, 5, 5);
        send_request(CMD_RELEASE, 9, 3);
        send_request(CMD_CHECK, 100, 100);
        send_request(CMD_CHECK, 30, 40);
        send_request(CMD_CHECK, 29, 40);
        send_request(CMD_LIST, 1, 2);
        send_request(CMD_MERGE, 3, 4);
        send_request(CMD_RELEASE, 12, 13);
        send_request(3'd5, 1, 2);
        send_request(3'd6, 32'hffffffff, 0);
        send_request(3'd7, 32'h55555555, 32'haaaaaaaa);
        send_request(CMD_MERGE, 0, 0);
        send_request(CMD_RELEASE, 32'h80000000, 32'h7fffffff);
        // Fill the table with gaps, then split one range to force a full refusal.
        for (int i = 0; i < MAX_RANGES; i++) send_request(CMD_ALLOC, i * 10, i * 10 + 5);
        send_request(CMD_RELEASE, 1, 2);
        send_request(CMD_ALLOC, 200, 201);
        send_request(CMD_LIST, 0, 0);
        send_request(CMD_MERGE, 0, 0);
        send_request(CMD_RELEASE, 32'h80000000, 32'h7fffffff);

        // Random part: mostly clustered ranges, some wide random values and odd codes.
        for (int i = 0; i < 320; i++) begin
            idle_free = (i / 40) % 3 == 2;
            base = ($urandom_range(0, 3) == 0) ? $urandom : 0;
            roll = $urandom_range(0, 99);
            if (roll < 40) cmd = CMD_ALLOC;
            else if (roll < 60) cmd = CMD_RELEASE;
            else if (roll < 75) cmd = CMD_CHECK;
            else if (roll < 85) cmd = CMD_LIST;
            else if (roll < 95) cmd = CMD_MERGE;
            else cmd = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 9) == 0) begin
                s = $urandom;
                e = $urandom;
            end else begin
                s = near_point(base);
                e = s + $signed($urandom_range(0, 12));
                if ($urandom_range(0, 7) == 0) e = s - $signed($urandom_range(0, 3));
            end
            send_request(cmd, s, e);
        end
        in_valid <= 0;
        idle_free = 0;

        // Drain: wait for outstanding results, then a few more cycles.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Sent %0d requests and checked %0d results.", request_count, result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
